// ----- rtl/core/mlpd_pkg.sv -----
// ----------------------------------------------------------------------------
// mlpd_pkg
// Shared types and constants for the magic/length packet deframer.
// ----------------------------------------------------------------------------
package mlpd_pkg;

   localparam int unsigned BUFFER_BYTES = 4096;
   localparam int unsigned HEADER_BYTES = 10;
   localparam int unsigned MAGIC_BYTES  = 4;

   localparam logic [31:0] PAYLOAD_CAP = 32'(BUFFER_BYTES - HEADER_BYTES);

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC0      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC1      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC2      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC3      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEEP_LIMIT  = 3'd5;

   localparam logic [11:0] LIMIT_RESET = 12'd4086;

   // header byte positions; below POS_VERSION the position counts window bytes
   localparam logic [3:0] POS_HUNT_FULL = 4'(MAGIC_BYTES - 1);
   localparam logic [3:0] POS_VERSION   = 4'(MAGIC_BYTES);
   localparam logic [3:0] POS_TYPE      = 4'(MAGIC_BYTES + 1);
   localparam logic [3:0] POS_LEN_LAST  = 4'(HEADER_BYTES - 1);

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_DROP  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       restart;
   } req_payload_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  msg_type;
      logic [7:0]  data;
      logic        kept;
      logic        last;
      logic [31:0] length;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0][7:0] magic;
      logic [11:0]     max_payload;
      logic [11:0]     keep_limit;
   } cfg_type;

endpackage

// ----- rtl/core/mlpd_csr.sv -----
// ----------------------------------------------------------------------------
// mlpd_csr
// Configuration registers: magic bytes, payload maximum and keep limit.
// ----------------------------------------------------------------------------
module mlpd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mlpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mlpd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output mlpd_pkg::cfg_type                cfg
);
   import mlpd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAGIC0:      cfg_in.magic[0]    = csr_wdata[7:0];
            CSR_MAGIC1:      cfg_in.magic[1]    = csr_wdata[7:0];
            CSR_MAGIC2:      cfg_in.magic[2]    = csr_wdata[7:0];
            CSR_MAGIC3:      cfg_in.magic[3]    = csr_wdata[7:0];
            CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_wdata;
            CSR_KEEP_LIMIT:  cfg_in.keep_limit  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic       <= '0;
         cfg_ff.max_payload <= LIMIT_RESET;
         cfg_ff.keep_limit  <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/mlpd_parser.sv -----
// ----------------------------------------------------------------------------
// mlpd_parser
// Framing state: magic hunt, header capture and payload byte tagging.
// ----------------------------------------------------------------------------
module mlpd_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  mlpd_pkg::req_payload_type req,
   input  mlpd_pkg::cfg_type         cfg,
   output logic                      res_valid,
   output mlpd_pkg::rsp_payload_type res
);
   import mlpd_pkg::*;

   logic [23:0] window_ff, window_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] len_ff, len_in;
   logic [11:0] idx_ff, idx_in;
   logic        payload_ff, payload_in;

   logic [23:0] cur_window;
   logic [3:0]  cur_pos;
   logic [7:0]  cur_type;
   logic [31:0] cur_len;
   logic [11:0] cur_idx;
   logic        cur_payload;
   logic [31:0] len_shift;
   logic        idx_last;
   logic        oversize;

   always_comb begin
      // restart clears framing before the byte is handled
      cur_window  = req.restart ? '0 : window_ff;
      cur_pos     = req.restart ? '0 : pos_ff;
      cur_type    = req.restart ? '0 : type_ff;
      cur_len     = req.restart ? '0 : len_ff;
      cur_idx     = req.restart ? '0 : idx_ff;
      cur_payload = req.restart ? 1'b0 : payload_ff;

      len_shift = {cur_len[23:0], req.rx_byte};
      idx_last  = ({20'd0, cur_idx} + 32'd1) == cur_len;
      oversize  = (len_shift > {20'd0, cfg.max_payload}) || (len_shift > PAYLOAD_CAP);

      window_in  = cur_window;
      pos_in     = cur_pos;
      type_in    = cur_type;
      len_in     = cur_len;
      idx_in     = cur_idx;
      payload_in = cur_payload;

      res_valid    = 1'b0;
      res.kind     = KIND_DATA;
      res.msg_type = cur_type;
      res.data     = '0;
      res.kept     = 1'b0;
      res.last     = 1'b1;
      res.length   = cur_len;

      priority if (cur_payload) begin
         res_valid = 1'b1;
         res.data  = req.rx_byte;
         res.kept  = cur_idx < cfg.keep_limit;
         res.last  = idx_last;
         idx_in    = cur_idx + 12'd1;
         if (idx_last) begin
            payload_in = 1'b0;
            idx_in     = '0;
            pos_in     = '0;
            window_in  = '0;
         end
      end else if (cur_pos < POS_VERSION) begin
         if (cur_pos == POS_HUNT_FULL &&
             cur_window == {cfg.magic[0], cfg.magic[1], cfg.magic[2]} &&
             req.rx_byte == cfg.magic[3]) begin
            pos_in    = POS_VERSION;
            window_in = '0;
         end else begin
            window_in = {cur_window[15:0], req.rx_byte};
            if (cur_pos < POS_HUNT_FULL) begin
               pos_in = cur_pos + 4'd1;
            end
         end
      end else if (cur_pos == POS_VERSION) begin
         pos_in = POS_TYPE;
      end else if (cur_pos == POS_TYPE) begin
         type_in = req.rx_byte;
         len_in  = '0;
         pos_in  = cur_pos + 4'd1;
      end else begin
         len_in = len_shift;
         if (cur_pos < POS_LEN_LAST) begin
            pos_in = cur_pos + 4'd1;
         end else begin
            pos_in     = '0;
            window_in  = '0;
            res.length = len_shift;
            priority if (oversize) begin
               res_valid = 1'b1;
               res.kind  = KIND_DROP;
            end else if (len_shift == '0) begin
               res_valid = 1'b1;
               res.kind  = KIND_EMPTY;
            end else begin
               payload_in = 1'b1;
               idx_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         pos_ff     <= '0;
         type_ff    <= '0;
         len_ff     <= '0;
         idx_ff     <= '0;
         payload_ff <= 1'b0;
      end else if (accept) begin
         window_ff  <= window_in;
         pos_ff     <= pos_in;
         type_ff    <= type_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
         payload_ff <= payload_in;
      end
   end

endmodule

// ----- rtl/core/mlpd_out_reg.sv -----
// ----------------------------------------------------------------------------
// mlpd_out_reg
// Result register; holds one result until its transfer completes.
// ----------------------------------------------------------------------------
module mlpd_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  mlpd_pkg::rsp_payload_type load_data,
   output logic                      space,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mlpd_pkg::rsp_payload_type rsp_payload
);
   import mlpd_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;

   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

// ----- rtl/core/magic_length_packet_deframer.sv -----
// A result is registered and presented in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the result register drains in the same
// cycle it reloads, so only a stalled rsp side holds off req.
// Reset (synchronous, active high) clears framing state and the result
// register and restores the default configuration.
// ----------------------------------------------------------------------------
// magic_length_packet_deframer
// Recovers magic-word, length-prefixed packets from a byte stream.
// ----------------------------------------------------------------------------
module magic_length_packet_deframer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mlpd_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mlpd_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_we,
   input  logic [mlpd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mlpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mlpd_pkg::*;

   cfg_type         cfg;
   logic            accept;
   logic            res_valid;
   rsp_payload_type res;
   logic            space;

   mlpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_ready = space;
   assign accept    = req_valid && space;

   mlpd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   mlpd_out_reg u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (accept && res_valid),
      .load_data   (res),
      .space       (space),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req not ready with empty result register");

   a_trailer_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind != KIND_DATA |->
         rsp_payload.last && rsp_payload.data == '0 && !rsp_payload.kept)
      else $error("empty or drop result with bad fields");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_EMPTY |-> rsp_payload.length == '0)
      else $error("empty packet with nonzero length");

   a_drop_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_DROP |-> rsp_payload.length != '0)
      else $error("oversize drop with zero length");

endmodule

// ----- bench/magic_length_packet_deframer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// magic_length_packet_deframer_test
// Self-checking bench for the magic/length packet deframer. Bytes are offered
// on the req side, with random gaps in most phases. A scoreboard class tracks
// its own copy of the framing state and the registers, predicts each result as
// bytes are accepted, and compares rsp transfers field by field. The run starts
// with a short directed sequence on reset defaults, then steps through several
// register settings. Each setting gets random framed packets mixed with noise,
// truncated headers and restarts. One phase stalls the rsp side long enough
// to back up the req side.
// ----------------------------------------------------------------------------
module magic_length_packet_deframer_test;
   import mlpd_pkg::*;

   class packet_scoreboard;
      logic [7:0]      magic [4];
      logic [11:0]     max_len;
      logic [11:0]     keep_len;
      logic [23:0]     window;
      logic [3:0]      hdr_pos;
      logic [7:0]      type_q;
      logic [31:0]     len_q;
      logic [11:0]     pay_idx;
      bit              in_pay;
      rsp_payload_type framed_outputs [$];
      int unsigned     failures;
      int unsigned     n_data;
      int unsigned     n_empty;
      int unsigned     n_drop;

      function new();
         foreach (magic[i]) magic[i] = 8'h00;
         max_len  = LIMIT_RESET;
         keep_len = LIMIT_RESET;
         failures = 0;
         n_data   = 0;
         n_empty  = 0;
         n_drop   = 0;
         clear_framing();
      endfunction

      function void clear_framing();
         window  = '0;
         hdr_pos = '0;
         type_q  = '0;
         len_q   = '0;
         pay_idx = '0;
         in_pay  = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_MAGIC0:      magic[0] = v[7:0];
            CSR_MAGIC1:      magic[1] = v[7:0];
            CSR_MAGIC2:      magic[2] = v[7:0];
            CSR_MAGIC3:      magic[3] = v[7:0];
            CSR_MAX_PAYLOAD: max_len  = v;
            CSR_KEEP_LIMIT:  keep_len = v;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return framed_outputs.size();
      endfunction

      function void add_output(kind_type k, logic [7:0] d, logic kept, logic last);
         rsp_payload_type r;
         r.kind     = k;
         r.msg_type = type_q;
         r.data     = d;
         r.kept     = kept;
         r.last     = last;
         r.length   = len_q;
         framed_outputs.push_back(r);
         case (k)
            KIND_DATA:  n_data++;
            KIND_EMPTY: n_empty++;
            default:    n_drop++;
         endcase
      endfunction

      // advance the framing state by one accepted byte
      function void note_byte(req_payload_type item);
         logic [7:0]  b;
         logic        last;
         logic [31:0] limit;
         b = item.rx_byte;
         if (item.restart) clear_framing();
         if (in_pay) begin
            last = (32'(pay_idx) + 32'd1) == len_q;
            add_output(KIND_DATA, b, pay_idx < keep_len, last);
            pay_idx = pay_idx + 12'd1;
            if (last) begin
               in_pay  = 1'b0;
               pay_idx = '0;
               hdr_pos = '0;
               window  = '0;
            end
            return;
         end
         if (hdr_pos < POS_VERSION) begin
            if (hdr_pos == POS_HUNT_FULL && window == {magic[0], magic[1], magic[2]}
                && b == magic[3]) begin
               hdr_pos = POS_VERSION;
               window  = '0;
            end else begin
               window = {window[15:0], b};
               if (hdr_pos < POS_HUNT_FULL) hdr_pos++;
            end
            return;
         end
         if (hdr_pos == POS_VERSION) begin
            hdr_pos = POS_TYPE;
            return;
         end
         if (hdr_pos == POS_TYPE) begin
            type_q  = b;
            len_q   = '0;
            hdr_pos = hdr_pos + 4'd1;
            return;
         end
         len_q = {len_q[23:0], b};
         if (hdr_pos < POS_LEN_LAST) begin
            hdr_pos = hdr_pos + 4'd1;
            return;
         end
         hdr_pos = '0;
         window  = '0;
         limit   = (32'(max_len) < PAYLOAD_CAP) ? 32'(max_len) : PAYLOAD_CAP;
         if (len_q > limit) begin
            add_output(KIND_DROP, 8'h00, 1'b0, 1'b1);
         end else if (len_q == 32'd0) begin
            add_output(KIND_EMPTY, 8'h00, 1'b0, 1'b1);
         end else begin
            in_pay  = 1'b1;
            pay_idx = '0;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (framed_outputs.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected rsp: kind=%0d type=%02h data=%02h kept=%0b last=%0b len=%0d",
                        got.kind, got.msg_type, got.data, got.kept, got.last, got.length);
            return;
         end
         want = framed_outputs.pop_front();
         if (got.kind !== want.kind || got.msg_type !== want.msg_type ||
             got.data !== want.data || got.kept !== want.kept ||
             got.last !== want.last || got.length !== want.length) begin
            failures++;
            if (failures <= 10) begin
               $display("rsp mismatch at %0t", $realtime);
               $display("  expected kind=%0d type=%02h data=%02h kept=%0b last=%0b len=%0d",
                        want.kind, want.msg_type, want.data, want.kept, want.last,
                        want.length);
               $display("  actual   kind=%0d type=%02h data=%02h kept=%0b last=%0b len=%0d",
                        got.kind, got.msg_type, got.data, got.kept, got.last, got.length);
            end
         end
      endfunction
   endclass

   localparam int CLOCK_PERIOD   = 10;
   localparam int LONG_HOLD      = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 190;
   localparam int NUM_PHASES     = 6;

   typedef logic [0:9][7:0] header_bytes_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_we      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   packet_scoreboard board;

   logic [7:0]  cur_magic [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
   logic [11:0] cur_max       = LIMIT_RESET;
   logic [11:0] cur_keep      = LIMIT_RESET;
   bit          tx_gaps       = 1'b0;
   bit          rx_stalls     = 1'b0;
   bit          long_hold_req = 1'b0;
   bit          restart_next  = 1'b0;
   int unsigned framed_bytes  = 0;
   int unsigned quiet_cycles  = 0;

   magic_length_packet_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_payload);
         if (req_valid && req_ready) board.note_byte(req_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // rsp side: random stall bursts, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [31:0] eff_max();
      return (32'(cur_max) < PAYLOAD_CAP) ? 32'(cur_max) : PAYLOAD_CAP;
   endfunction

   function automatic logic [31:0] pick_length();
      logic [31:0] cap;
      cap = eff_max();
      case ($urandom_range(0, 11))
         0:       return 32'd0;
         1:       return (cap <= 32'd64) ? cap : 32'($urandom_range(1, 24));
         2:       return cap + 32'd1;
         3:       return $urandom();
         4:       return 32'($urandom_range(25, 160));
         default: return 32'($urandom_range(1, 24));
      endcase
   endfunction

   function automatic header_bytes_type make_header(logic [7:0] ver, logic [7:0] typ,
                                                    logic [31:0] len);
      return {cur_magic[0], cur_magic[1], cur_magic[2], cur_magic[3], ver, typ, len};
   endfunction

   function automatic logic [7:0] noise_byte();
      return ($urandom_range(0, 3) == 0) ? cur_magic[$urandom_range(0, 3)] : 8'($urandom);
   endfunction

   task automatic push_byte(logic [7:0] b, logic rs);
      req_payload_type item;
      item.rx_byte = b;
      item.restart = rs;
      if (tx_gaps && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_header(logic [7:0] ver, logic [7:0] typ, logic [31:0] len);
      header_bytes_type hdr;
      hdr = make_header(ver, typ, len);
      for (int k = 0; k < 10; k++) push_byte(hdr[k], (k == 0) && restart_next);
      restart_next = 1'b0;
      framed_bytes += 10;
   endtask

   task automatic send_packet(logic [31:0] len);
      send_header(8'($urandom), 8'($urandom), len);
      if (len != 32'd0 && len <= eff_max()) begin
         for (int k = 0; k < int'(len); k++)
            push_byte(8'($urandom), $urandom_range(0, 399) == 0);
         framed_bytes += len;
      end
   endtask

   // header cut short; the next header carries a restart
   task automatic send_truncated();
      header_bytes_type hdr;
      int               n;
      hdr = make_header(8'($urandom), 8'($urandom), pick_length());
      n   = $urandom_range(1, 9);
      for (int k = 0; k < n; k++) push_byte(hdr[k], (k == 0) && restart_next);
      restart_next = 1'b1;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs();
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  value;
      for (int i = 0; i < (1 << CSR_INDEX_W); i++) begin
         idx = CSR_INDEX_W'(i);
         case (idx)
            CSR_MAGIC0, CSR_MAGIC1, CSR_MAGIC2, CSR_MAGIC3:
               value = {4'($urandom), cur_magic[idx[1:0]]};
            CSR_MAX_PAYLOAD: value = cur_max;
            CSR_KEEP_LIMIT:  value = cur_keep;
            default:         value = CSR_DATA_W'($urandom);
         endcase
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(posedge clock);
         board.write_reg(idx, value);
      end
      csr_we <= 1'b0;
   endtask

   task automatic pick_settings(int p);
      foreach (cur_magic[i]) cur_magic[i] = 8'($urandom);
      case (p)
         0: begin
            cur_magic = '{8'hAA, 8'hAA, 8'hAA, 8'hAA};
            cur_max   = 12'hFFF;
            cur_keep  = 12'hFFF;
         end
         1: begin
            cur_max  = 12'd32;
            cur_keep = 12'd8;
         end
         2: begin
            cur_max  = 12'($urandom_range(0, 300));
            cur_keep = 12'($urandom_range(0, 64));
         end
         3: begin
            cur_magic = '{8'hFF, 8'h00, 8'hFF, 8'h00};
            cur_max   = 12'd0;
            cur_keep  = 12'd0;
         end
         4: begin
            cur_max  = LIMIT_RESET;
            cur_keep = 12'($urandom_range(0, 4095));
         end
         default: begin
            cur_max  = 12'($urandom_range(1, 100));
            cur_keep = 12'($urandom_range(0, 100));
         end
      endcase
   endtask

   task automatic run_random_phase(int unsigned target);
      int unsigned start;
      int unsigned sel;
      start = framed_bytes;
      while (framed_bytes - start < target) begin
         sel = $urandom_range(0, 19);
         if (sel < 2) begin
            repeat ($urandom_range(1, 4)) push_byte(noise_byte(), 1'b0);
         end else if (sel < 4) begin
            send_truncated();
         end else begin
            send_packet(pick_length());
         end
      end
   endtask

   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: zero magic, so leading zeros must not match early
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
      repeat (3) push_byte(8'h00, 1'b0);
      restart_next = 1'b1;
      send_header(8'hFF, 8'hA5, 32'd2);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      send_header(8'h00, 8'h00, 32'hFFFF_FFFF);
      send_header(8'h7F, 8'hFF, 32'd0);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         pick_settings(p);
         program_regs();
         tx_gaps   = (p != NUM_PHASES - 1) && (p % 3 != 2);
         rx_stalls = (p != NUM_PHASES - 1) && (p % 2 == 0);
         if (p == 1) begin
            // stall rsp while a full-size packet streams in
            long_hold_req = 1'b1;
            send_packet(32'd32);
         end
         run_random_phase(PHASE_BYTES);
      end

      wait_idle();
      $display("Run covered %0d framed bytes under reset defaults and %0d register settings,",
               framed_bytes, NUM_PHASES);
      $display("with noise, cut headers and restarts: %0d data, %0d empty, %0d drop transfers.",
               board.n_data, board.n_empty, board.n_drop);
      if (board.failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches in total", board.failures);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/mlpd_pkg.sv
rtl/core/mlpd_csr.sv
rtl/core/mlpd_parser.sv
rtl/core/mlpd_out_reg.sv
rtl/core/magic_length_packet_deframer.sv
bench/magic_length_packet_deframer_test.sv
